### hw/rtl/lers_pkg.sv
// ----------------------------------------------------------------------------
// lers_pkg
// Shared types and constants of the least-expansion rectangle selector.
// ----------------------------------------------------------------------------
package lers_pkg;

  // Coordinate and field widths
  localparam int COORD_BITS    = 16;
  localparam int EXT_BITS      = COORD_BITS + 1;   // grown extent reaches 2^COORD_BITS
  localparam int IDX_BITS      = 4;                // width of the best_index field
  localparam int ENL_BITS      = 34;               // width of the enlargement field
  localparam int MAX_RECTS_DEF = 16;

  // Operation codes
  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_LOAD  = 2'd1;
  localparam op_t OP_QUERY = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ENL_BITS-1:0]   enl_t;

  // Enlargement codes: contained point, and no candidate (saturated maximum)
  localparam enl_t ENL_CONTAINED = {ENL_BITS{1'b1}};
  localparam enl_t ENL_NONE      = enl_t'(64'sd4294967296);
  localparam enl_t ENL_ZERO      = '0;

  // One stored rectangle, as held in the memory
  typedef struct packed {
    coord_t lx;
    coord_t ly;
    coord_t ux;
    coord_t uy;
  } rect_t;

  // Per-rectangle evaluation handed from the datapath to the selector
  typedef struct packed {
    logic vld;
    logic hit;
    logic nz;
    enl_t enl;
  } eval_t;

endpackage

### hw/rtl/least_expansion_rectangle_select.sv
// ----------------------------------------------------------------------------
// least_expansion_rectangle_select
// Rectangle store with containment and least-area-enlargement point query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_* (valid/ready) carries one item: an op code plus the
//   rectangle bounds (load) or the point (query). Every item gives exactly
//   one result item on out_* (valid/ready).
//   Clear and load finish in the accept cycle; the result is valid on the
//   next cycle. A query reads the rectangle memory once per stored
//   rectangle through a three-stage evaluation pipeline, then waits for
//   the pipeline to drain before the result is registered (an empty store
//   skips the scan). The single memory read port serializes the scan, and
//   the next item is taken only once the query's result is registered.
//   The block holds one item at a time. The output register lets the next
//   item be accepted in the cycle the previous result is taken; while the
//   receiver stalls, the result holds and no new item is accepted.
//   Reset empties the store and the bounding box; the memory contents are
//   left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module least_expansion_rectangle_select #(
  parameter int MAX_RECTS = lers_pkg::MAX_RECTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lers_pkg::op_t                     in_op,
  input  lers_pkg::coord_t                  in_lower_x,
  input  lers_pkg::coord_t                  in_lower_y,
  input  lers_pkg::coord_t                  in_upper_x,
  input  lers_pkg::coord_t                  in_upper_y,
  input  lers_pkg::coord_t                  in_point_x,
  input  lers_pkg::coord_t                  in_point_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_status,
  output logic                              out_contained,
  output logic                              out_found,
  output logic [lers_pkg::IDX_BITS-1:0]     out_best_index,
  output lers_pkg::enl_t                    out_enlargement
);
  import lers_pkg::*;

  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Rectangle memory
  rect_t mem [MAX_RECTS];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  coord_t            px_r, px_nxt, py_r, py_nxt;
  logic              bb_vld_r, bb_vld_nxt;
  coord_t            bb_lx_r, bb_lx_nxt, bb_ly_r, bb_ly_nxt;
  coord_t            bb_ux_r, bb_ux_nxt, bb_uy_r, bb_uy_nxt;
  logic              bb_hold_r, bb_hold_nxt;
  logic              any_hit_r, any_hit_nxt;
  logic              fnd_r, fnd_nxt;
  enl_t              best_r, best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_contained_r, out_contained_nxt;
  logic              out_found_r, out_found_nxt;
  logic [IDX_BITS-1:0] out_idx_r, out_idx_nxt;
  enl_t              out_enl_r, out_enl_nxt;

  rect_t             rd_data_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              mem_we;
  rect_t             wr_rect;

  eval_t             ev_res;
  logic [IDX_W-1:0]  ev_idx;
  logic              ev_busy;

  logic              in_acc, out_space, scan_last;

  assign out_space = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_space;
  assign in_acc    = in_valid && in_ready;
  assign scan_last = (CNT_W'(addr_r) == (cnt_r - CNT_W'(1)));

  assign wr_rect.lx = in_lower_x;
  assign wr_rect.ly = in_lower_y;
  assign wr_rect.ux = in_upper_x;
  assign wr_rect.uy = in_upper_y;

  // Memory: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_r[IDX_W-1:0]] <= wr_rect;
    rd_data_r <= mem[addr_r];
    rd_idx_r  <= addr_r;
  end

  // Per-rectangle evaluation pipeline
  lers_eval #(
    .IDX_W (IDX_W)
  ) u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .in_idx  (rd_idx_r),
    .rect    (rd_data_r),
    .px      (px_r),
    .py      (py_r),
    .res     (ev_res),
    .res_idx (ev_idx),
    .busy    (ev_busy)
  );

  // Next-state logic
  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    addr_nxt          = addr_r;
    px_nxt            = px_r;
    py_nxt            = py_r;
    bb_vld_nxt        = bb_vld_r;
    bb_lx_nxt         = bb_lx_r;
    bb_ly_nxt         = bb_ly_r;
    bb_ux_nxt         = bb_ux_r;
    bb_uy_nxt         = bb_uy_r;
    bb_hold_nxt       = bb_hold_r;
    any_hit_nxt       = any_hit_r;
    fnd_nxt           = fnd_r;
    best_nxt          = best_r;
    best_idx_nxt      = best_idx_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_status_nxt    = out_status_r;
    out_contained_nxt = out_contained_r;
    out_found_nxt     = out_found_r;
    out_idx_nxt       = out_idx_r;
    out_enl_nxt       = out_enl_r;
    mem_we            = 1'b0;

    // Running best over evaluated rectangles; lowest index wins ties
    if (ev_res.vld) begin
      if (ev_res.hit) any_hit_nxt = 1'b1;
      if (ev_res.nz && (!fnd_r || (ev_res.enl < best_r))) begin
        fnd_nxt      = 1'b1;
        best_nxt     = ev_res.enl;
        best_idx_nxt = ev_idx;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // clear/load/unused codes answer at once with a zero result (a dropped load sets status)
          out_valid_nxt     = 1'b1;
          out_status_nxt    = 1'b0;
          out_contained_nxt = 1'b0;
          out_found_nxt     = 1'b0;
          out_idx_nxt       = '0;
          out_enl_nxt       = ENL_ZERO;
          unique case (in_op)
            OP_CLEAR: begin
              cnt_nxt    = '0;
              bb_vld_nxt = 1'b0;
            end
            OP_LOAD: begin
              if (cnt_r == CNT_W'(MAX_RECTS)) begin
                out_status_nxt = 1'b1;
              end else begin
                mem_we     = 1'b1;
                cnt_nxt    = cnt_r + CNT_W'(1);
                bb_vld_nxt = 1'b1;
                if (!bb_vld_r || (in_lower_x < bb_lx_r)) bb_lx_nxt = in_lower_x;
                if (!bb_vld_r || (in_lower_y < bb_ly_r)) bb_ly_nxt = in_lower_y;
                if (!bb_vld_r || (in_upper_x > bb_ux_r)) bb_ux_nxt = in_upper_x;
                if (!bb_vld_r || (in_upper_y > bb_uy_r)) bb_uy_nxt = in_upper_y;
              end
            end
            OP_QUERY: begin
              out_valid_nxt = out_valid_r && !out_ready;
              px_nxt        = in_point_x;
              py_nxt        = in_point_y;
              bb_hold_nxt   = bb_vld_r &&
                              (bb_lx_r <= in_point_x) && (in_point_x < bb_ux_r) &&
                              (bb_ly_r <= in_point_y) && (in_point_y < bb_uy_r);
              any_hit_nxt   = 1'b0;
              fnd_nxt       = 1'b0;
              best_nxt      = ENL_ZERO;
              best_idx_nxt  = '0;
              addr_nxt      = '0;
              state_nxt     = (cnt_r == '0) ? ST_DONE : ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + IDX_W'(1);
        if (scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !ev_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_space) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          priority if (bb_hold_r && any_hit_r) begin
            out_contained_nxt = 1'b1;
            out_found_nxt     = 1'b0;
            out_idx_nxt       = '0;
            out_enl_nxt       = ENL_CONTAINED;
          end else if (fnd_r) begin
            out_contained_nxt = 1'b0;
            out_found_nxt     = 1'b1;
            out_idx_nxt       = IDX_BITS'(best_idx_r);
            out_enl_nxt       = best_r;
          end else begin
            out_contained_nxt = 1'b0;
            out_found_nxt     = 1'b0;
            out_idx_nxt       = '0;
            out_enl_nxt       = ENL_NONE;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      bb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bb_vld_r    <= bb_vld_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r          <= addr_nxt;
    px_r            <= px_nxt;
    py_r            <= py_nxt;
    bb_lx_r         <= bb_lx_nxt;
    bb_ly_r         <= bb_ly_nxt;
    bb_ux_r         <= bb_ux_nxt;
    bb_uy_r         <= bb_uy_nxt;
    bb_hold_r       <= bb_hold_nxt;
    any_hit_r       <= any_hit_nxt;
    fnd_r           <= fnd_nxt;
    best_r          <= best_nxt;
    best_idx_r      <= best_idx_nxt;
    out_status_r    <= out_status_nxt;
    out_contained_r <= out_contained_nxt;
    out_found_r     <= out_found_nxt;
    out_idx_r       <= out_idx_nxt;
    out_enl_r       <= out_enl_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_contained   = out_contained_r;
  assign out_found       = out_found_r;
  assign out_best_index  = out_idx_r;
  assign out_enlargement = out_enl_r;

endmodule

### hw/rtl/lers_eval.sv
// ----------------------------------------------------------------------------
// lers_eval
// Three-stage datapath: containment, grown and own extents, areas, and the
// area enlargement of one stored rectangle against the query point.
// ----------------------------------------------------------------------------
module lers_eval #(
  parameter int IDX_W = lers_pkg::IDX_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [IDX_W-1:0]   in_idx,
  input  lers_pkg::rect_t    rect,
  input  lers_pkg::coord_t   px,
  input  lers_pkg::coord_t   py,
  output lers_pkg::eval_t    res,
  output logic [IDX_W-1:0]   res_idx,
  output logic               busy
);
  import lers_pkg::*;

  localparam int WW = COORD_BITS + 2;
  localparam int GW = 2 * EXT_BITS;
  localparam int AW = 2 * COORD_BITS;
  localparam int DW = GW + 1;

  typedef logic signed [WW-1:0] wide_t;

  // Extent of [min(l,p), max(u,p+1)); always positive
  function automatic logic [EXT_BITS-1:0] grow_ext(coord_t l, coord_t u, coord_t p);
    wide_t lw, uw, pw, p1, lo, hi, d;
    lw = wide_t'(l);
    uw = wide_t'(u);
    pw = wide_t'(p);
    p1 = pw + wide_t'(1);
    lo = (lw < pw) ? lw : pw;
    hi = (uw > p1) ? uw : p1;
    d  = hi - lo;
    return d[EXT_BITS-1:0];
  endfunction

  // Absolute extent |u - l|
  function automatic logic [COORD_BITS-1:0] span(coord_t l, coord_t u);
    wide_t d;
    d = wide_t'(u) - wide_t'(l);
    if (d < 0) d = -d;
    return d[COORD_BITS-1:0];
  endfunction

  logic                   s1_vld_r, s2_vld_r, s3_vld_r;
  logic [IDX_W-1:0]       s1_idx_r, s2_idx_r, s3_idx_r;
  logic                   s1_hit_r, s2_hit_r, s3_hit_r;
  logic [EXT_BITS-1:0]    s1_gx_r, s1_gy_r;
  logic [COORD_BITS-1:0]  s1_ax_r, s1_ay_r;
  logic                   s2_nz_r, s3_nz_r;
  logic [GW-1:0]          s2_grown_r;
  logic [AW-1:0]          s2_area_r;
  enl_t                   s3_enl_r;
  logic signed [DW-1:0]   diff;
  logic                   hit;

  assign hit = (rect.lx <= px) && (px < rect.ux) && (rect.ly <= py) && (py < rect.uy);
  assign diff = $signed(DW'(s2_grown_r)) - $signed(DW'(s2_area_r));

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Stage payloads: extents, products, difference
  always_ff @(posedge clk) begin
    s1_idx_r   <= in_idx;
    s1_hit_r   <= hit;
    s1_gx_r    <= grow_ext(rect.lx, rect.ux, px);
    s1_gy_r    <= grow_ext(rect.ly, rect.uy, py);
    s1_ax_r    <= span(rect.lx, rect.ux);
    s1_ay_r    <= span(rect.ly, rect.uy);

    s2_idx_r   <= s1_idx_r;
    s2_hit_r   <= s1_hit_r;
    s2_nz_r    <= (s1_ax_r != '0) && (s1_ay_r != '0);
    s2_grown_r <= s1_gx_r * s1_gy_r;
    s2_area_r  <= s1_ax_r * s1_ay_r;

    s3_idx_r   <= s2_idx_r;
    s3_hit_r   <= s2_hit_r;
    s3_nz_r    <= s2_nz_r;
    s3_enl_r   <= diff[ENL_BITS-1:0];
  end

  assign res.vld = s3_vld_r;
  assign res.hit = s3_hit_r;
  assign res.nz  = s3_nz_r;
  assign res.enl = s3_enl_r;
  assign res_idx = s3_idx_r;
  assign busy    = s1_vld_r | s2_vld_r | s3_vld_r;

endmodule

### hw/rtl/lers_checker.sv
// ----------------------------------------------------------------------------
// lers_checker
// Port-level assertions for the rectangle selector, bound to the top level.
// ----------------------------------------------------------------------------
module lers_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input lers_pkg::op_t                 in_op,
  input lers_pkg::coord_t              in_lower_x,
  input lers_pkg::coord_t              in_lower_y,
  input lers_pkg::coord_t              in_upper_x,
  input lers_pkg::coord_t              in_upper_y,
  input lers_pkg::coord_t              in_point_x,
  input lers_pkg::coord_t              in_point_y,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_status,
  input logic                          out_contained,
  input logic                          out_found,
  input logic [lers_pkg::IDX_BITS-1:0] out_best_index,
  input lers_pkg::enl_t                out_enlargement
);
  import lers_pkg::*;

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_contained) && $stable(out_found) &&
      $stable(out_best_index) && $stable(out_enlargement))
    else $error("stalled result item changed");

  // Clear, load and unused codes answer in the next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_QUERY) |=> out_valid)
    else $error("non-query item did not answer in one cycle");

  // A contained query reports -1 and no candidate
  a_contained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_contained |->
      !out_found && !out_status && (out_enlargement == ENL_CONTAINED) &&
      (out_best_index == '0))
    else $error("contained result malformed");

  // A dropped load reports nothing else
  a_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |->
      !out_contained && !out_found && (out_enlargement == ENL_ZERO))
    else $error("dropped-load result malformed");

endmodule

bind least_expansion_rectangle_select lers_checker u_lers_checker (.*);

### test/tb_least_expansion_rectangle_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_expansion_rectangle_select
// Self-checking bench for the least-expansion rectangle selector.
// A shadow copy of the rectangle store predicts every result: clear, load,
// dropped load on a full store, and the containment / least-enlargement
// query. Directed corner items come first, then random clear-load-query
// sequences with some noise, under changing idle rates on both channels
// and one long output stall.
// ----------------------------------------------------------------------------
module tb_least_expansion_rectangle_select;
  import lers_pkg::*;

  localparam int     MAX_RECTS     = MAX_RECTS_DEF;
  localparam op_t    OP_UNUSED     = 2'd3;
  localparam longint SAT_LIMIT     = 64'sd4294967296;
  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     DRAIN_CYCLES  = 40;
  localparam int     LONG_HOLD     = 160;
  localparam int     PRINT_LIMIT   = 50;

  typedef struct {
    logic                status;
    logic                contained;
    logic                found;
    logic [IDX_BITS-1:0] best_index;
    enl_t                enlargement;
  } result_t;

  logic   clk        = 1'b0;
  logic   rst_n      = 1'b0;
  logic   in_valid   = 1'b0;
  logic   in_ready;
  op_t    in_op      = OP_CLEAR;
  coord_t in_lower_x = '0;
  coord_t in_lower_y = '0;
  coord_t in_upper_x = '0;
  coord_t in_upper_y = '0;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_status;
  logic                out_contained;
  logic                out_found;
  logic [IDX_BITS-1:0] out_best_index;
  enl_t                out_enlargement;

  // Shadow store of the block
  rect_t       shadow_rects [MAX_RECTS];
  int unsigned shadow_count = 0;

  result_t pending_results [$];
  int      error_count   = 0;
  int      results_seen  = 0;
  int      cycle_count   = 0;
  int      tx_idle_pct   = 14;
  int      rx_idle_pct   = 72;
  int      hold_req      = 0;
  int      hold_ack      = 0;
  int      hold_left     = 0;

  least_expansion_rectangle_select #(.MAX_RECTS(MAX_RECTS)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_lower_x      (in_lower_x),
    .in_lower_y      (in_lower_y),
    .in_upper_x      (in_upper_x),
    .in_upper_y      (in_upper_y),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_contained   (out_contained),
    .out_found       (out_found),
    .out_best_index  (out_best_index),
    .out_enlargement (out_enlargement)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint span(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Updates the shadow store and returns the result the item should give.
  // The bounding box is not tracked: any rectangle that holds the point lies
  // inside the box, so the box check never changes the outcome.
  function automatic result_t predict_item(op_t op, coord_t lx, coord_t ly,
                                           coord_t ux, coord_t uy,
                                           coord_t px, coord_t py);
    result_t r;
    longint  grown, area, enl, best, lo, hi;
    bit      hit, fnd;
    int      best_i;
    r.status      = 1'b0;
    r.contained   = 1'b0;
    r.found       = 1'b0;
    r.best_index  = '0;
    r.enlargement = ENL_ZERO;
    hit    = 1'b0;
    fnd    = 1'b0;
    best   = 0;
    best_i = 0;
    case (op)
      OP_CLEAR: shadow_count = 0;
      OP_LOAD: begin
        if (shadow_count >= MAX_RECTS) begin
          r.status = 1'b1;
        end else begin
          shadow_rects[shadow_count] = '{lx: lx, ly: ly, ux: ux, uy: uy};
          shadow_count++;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_rects[i].lx <= px && px < shadow_rects[i].ux &&
              shadow_rects[i].ly <= py && py < shadow_rects[i].uy)
            hit = 1'b1;
        end
        if (hit) begin
          r.contained   = 1'b1;
          r.enlargement = ENL_CONTAINED;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            // x extent grown to hold the point (upper bound is point + 1)
            lo    = (longint'(shadow_rects[i].lx) < longint'(px)) ?
                    longint'(shadow_rects[i].lx) : longint'(px);
            hi    = (longint'(shadow_rects[i].ux) > longint'(px) + 1) ?
                    longint'(shadow_rects[i].ux) : longint'(px) + 1;
            grown = span(lo, hi);
            area  = span(shadow_rects[i].lx, shadow_rects[i].ux);
            // y extent
            lo    = (longint'(shadow_rects[i].ly) < longint'(py)) ?
                    longint'(shadow_rects[i].ly) : longint'(py);
            hi    = (longint'(shadow_rects[i].uy) > longint'(py) + 1) ?
                    longint'(shadow_rects[i].uy) : longint'(py) + 1;
            grown = grown * span(lo, hi);
            area  = area * span(shadow_rects[i].ly, shadow_rects[i].uy);
            if (area != 0) begin
              enl = grown - area;
              if (!fnd || enl < best) begin
                fnd    = 1'b1;
                best   = enl;
                best_i = i;
              end
            end
          end
          if (fnd) begin
            if (best > SAT_LIMIT)  best = SAT_LIMIT;
            if (best < -SAT_LIMIT) best = -SAT_LIMIT;
            r.found       = 1'b1;
            r.best_index  = best_i[IDX_BITS-1:0];
            r.enlargement = enl_t'(best);
          end else begin
            r.enlargement = ENL_NONE;
          end
        end
      end
      default: ;  // unused code: no state change, all-zero result
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Call at a rising edge; returns at the edge where the item was taken.
  task automatic send_item(op_t op, coord_t lx, coord_t ly, coord_t ux,
                           coord_t uy, coord_t px, coord_t py);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_lower_x <= lx;
    in_lower_y <= ly;
    in_upper_x <= ux;
    in_upper_y <= uy;
    in_point_x <= px;
    in_point_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted       = predict_item(op, lx, ly, ux, uy, px, py);
    pending_results = {pending_results, predicted};
  endtask

  // Mostly small coordinates so rectangles overlap, plus extremes and full range
  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return coord_t'(16'h8000);
          1:       return coord_t'(16'h7fff);
          2:       return coord_t'(16'h0000);
          default: return coord_t'(16'hffff);
        endcase
      end
      1, 2:    return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(127)) - 64);
    endcase
  endfunction

  task automatic send_load(coord_t lx, coord_t ly, coord_t ux, coord_t uy);
    send_item(OP_LOAD, lx, ly, ux, uy, pick_coord(), pick_coord());
  endtask

  task automatic send_query(coord_t px, coord_t py);
    send_item(OP_QUERY, pick_coord(), pick_coord(), pick_coord(), pick_coord(), px, py);
  endtask

  // Mostly well-formed rectangles, some empty or inverted ones
  task automatic send_random_load();
    coord_t lx, ly;
    lx = pick_coord();
    ly = pick_coord();
    if ($urandom_range(5) == 0)
      send_load(lx, ly, pick_coord(), pick_coord());
    else
      send_load(lx, ly, coord_t'(int'(lx) + int'($urandom_range(40))),
                coord_t'(int'(ly) + int'($urandom_range(40))));
  endtask

  task automatic idle_inputs();
    in_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint want, longint got);
    if (error_count < PRINT_LIMIT)
      $display("ERROR result %0d: %s expected %0d got %0d", results_seen, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, count", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", want.status, out_status);
        if (out_contained !== want.contained)
          report_mismatch("contained", want.contained, out_contained);
        if (out_found !== want.found)
          report_mismatch("found", want.found, out_found);
        if (out_best_index !== want.best_index)
          report_mismatch("best_index", want.best_index, out_best_index);
        if (out_enlargement !== want.enlargement)
          report_mismatch("enlargement", longint'(want.enlargement),
                          longint'(out_enlargement));
      end
      results_seen++;
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL least_expansion_rectangle_select");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Corner cases: empty set, unused code, full-range bounds, top of range
  // point, zero-area and inverted rectangles, ties
  task automatic test_directed();
    send_query(coord_t'(0), coord_t'(0));
    send_item(OP_UNUSED, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord());
    send_load(coord_t'(16'h8000), coord_t'(16'h8000), coord_t'(16'h7fff),
              coord_t'(16'h7fff));
    send_query(coord_t'(16'h7fff), coord_t'(16'h7fff));
    send_query(coord_t'(16'h8000), coord_t'(16'h8000));
    send_query(coord_t'(16'h7fff), coord_t'(16'h8000));
    send_item(OP_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord());
    send_load(coord_t'(5), coord_t'(5), coord_t'(5), coord_t'(10));
    send_query(coord_t'(0), coord_t'(0));
    send_load(coord_t'(10), coord_t'(10), coord_t'(0), coord_t'(0));
    send_query(coord_t'(5), coord_t'(5));
    send_load(coord_t'(0), coord_t'(0), coord_t'(4), coord_t'(4));
    send_load(coord_t'(0), coord_t'(0), coord_t'(4), coord_t'(4));
    send_query(coord_t'(20), coord_t'(20));
    send_query(coord_t'(2), coord_t'(2));
    send_query(coord_t'(16'h8000), coord_t'(16'h7fff));
  endtask

  // Fill the store, then loads are dropped while queries still see all 16
  task automatic test_full_store();
    send_item(OP_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord());
    repeat (MAX_RECTS) send_random_load();
    send_random_load();
    send_query(pick_coord(), pick_coord());
    send_random_load();
  endtask

  // Clear, a run of loads, a run of queries; now and then noise or no clear
  task automatic test_random_traffic(int n_items);
    int sent;
    int n_loads;
    int n_queries;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(op_t'($urandom_range(3)), pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord());
        sent++;
      end else begin
        if ($urandom_range(5) != 0) begin
          send_item(OP_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord());
          sent++;
        end
        n_loads   = ($urandom_range(4) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
        n_queries = $urandom_range(2, 8);
        repeat (n_loads) begin
          send_random_load();
          sent++;
        end
        repeat (n_queries) begin
          send_query(pick_coord(), pick_coord());
          sent++;
        end
      end
    end
  endtask

  // Long output stall while items keep coming, so the input backs up
  task automatic test_output_backpressure();
    hold_req <= hold_req + 1;
    repeat (4) send_random_load();
    repeat (6) send_query(pick_coord(), pick_coord());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_store();
    test_random_traffic(200);
    test_output_backpressure();

    tx_idle_pct = 72;
    rx_idle_pct = 14;
    test_random_traffic(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(190);

    idle_inputs();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS least_expansion_rectangle_select");
    else
      $display("FAIL least_expansion_rectangle_select");
    $finish;
  end

endmodule
